// ===== src/assert_macros.svh =====
// Shared assertion macros for the directory block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the next cycle, muted while reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fdsa_pkg.sv =====
package fdsa_pkg;

    localparam int DIR_ENTRIES      = 16;
    localparam int NAME_CHARS       = 6;
    localparam int MAX_FILE_SECTORS = 26;
    localparam int DISK_SECTORS     = 256;

    localparam int NAME_W   = 8 * NAME_CHARS;
    localparam int OP_W     = 2;
    localparam int CNT_W    = 5;
    localparam int STAT_W   = 3;
    localparam int SECNUM_W = 8;
    localparam int CFG_W    = 9;
    localparam int EIDX_W   = 4;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EXISTS    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DIR_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DISK_FULL = 3'd4;

    localparam logic [CFG_W-1:0] RESERVED_RESET = 9'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              empty_name;
        logic [NAME_W-1:0] key;
        logic [CNT_W-1:0]  want;
    } req_t;

endpackage

// ===== src/fdsa_front.sv =====
module fdsa_front
(
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [fdsa_pkg::OP_W-1:0]     opcode,
    input  logic [47:0]                   file_name,
    input  logic [fdsa_pkg::CNT_W-1:0]    sector_count,
    input  logic                          q_full,
    output logic                          q_push,
    output fdsa_pkg::req_t                q_data
);

    logic [fdsa_pkg::NAME_W-1:0] key;
    logic                        ended;

    // The name ends at the first zero byte; later bytes are dropped.
    always_comb
    begin
        key   = '0;
        ended = 1'b0;
        for (int j = 0; j < fdsa_pkg::NAME_CHARS; j++)
        begin
            if (file_name[8*j +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                key[8*j +: 8] = file_name[8*j +: 8];
            end
        end
    end

    assign req_stall = q_full;

    // Unknown opcodes are taken and dropped here.
    assign q_push = req_valid && !q_full &&
                    (opcode == fdsa_pkg::OP_LOOKUP || opcode == fdsa_pkg::OP_CREATE ||
                     opcode == fdsa_pkg::OP_DELETE);

    always_comb
    begin
        q_data.op         = opcode;
        q_data.empty_name = (key[7:0] == 8'd0);
        q_data.key        = key;
        if (sector_count > fdsa_pkg::CNT_W'(fdsa_pkg::MAX_FILE_SECTORS))
        begin
            q_data.want = fdsa_pkg::CNT_W'(fdsa_pkg::MAX_FILE_SECTORS);
        end
        else
        begin
            q_data.want = sector_count;
        end
    end

endmodule

// ===== src/fdsa_queue.sv =====
module fdsa_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fdsa_pkg::req_t push_data,
    input  logic           pop,
    output fdsa_pkg::req_t head,
    output logic           full,
    output logic           empty
);

    fdsa_pkg::req_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/fdsa_back.sv =====
module fdsa_back
#(
    parameter int DIR_ENTRIES  = fdsa_pkg::DIR_ENTRIES,
    parameter int DISK_SECTORS = fdsa_pkg::DISK_SECTORS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fdsa_pkg::CFG_W-1:0]       reserved,
    input  logic                             q_empty,
    input  fdsa_pkg::req_t                   q_head,
    output logic                             q_pop,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [fdsa_pkg::STAT_W-1:0]      status,
    output logic [fdsa_pkg::EIDX_W-1:0]      entry_index,
    output logic                             sector_valid,
    output logic [fdsa_pkg::SECNUM_W-1:0]    sector_number,
    output logic [fdsa_pkg::CNT_W-1:0]       file_sectors,
    output logic                             last
);

    localparam int IDX_W  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int KW     = $clog2(DIR_ENTRIES + 1);
    localparam int SEC_W  = $clog2(DISK_SECTORS);
    localparam int LDEPTH = DIR_ENTRIES * fdsa_pkg::MAX_FILE_SECTORS;
    localparam int LA_W   = $clog2(LDEPTH);
    localparam int CNT_W  = fdsa_pkg::CNT_W;
    localparam int CFG_W  = fdsa_pkg::CFG_W;

    typedef enum logic [7:0]
    {
        ST_IDLE  = 8'b00000001,
        ST_SCAN  = 8'b00000010,
        ST_ALLOC = 8'b00000100,
        ST_DEL   = 8'b00001000,
        ST_RD    = 8'b00010000,
        ST_OUT   = 8'b00100000,
        ST_TAIL  = 8'b01000000,
        ST_CLR   = 8'b10000000
    } back_state_t;

    back_state_t                      state_reg;
    fdsa_pkg::req_t                   req_reg;
    logic [KW-1:0]                    k_reg;
    logic                             hit_reg;
    logic [IDX_W-1:0]                 hit_idx_reg;
    logic                             free_reg;
    logic [IDX_W-1:0]                 free_idx_reg;
    logic [IDX_W-1:0]                 e_reg;
    logic [CNT_W-1:0]                 n_reg;
    logic [CNT_W-1:0]                 i_reg;
    logic [CFG_W-1:0]                 s_reg;
    logic                             tail_after_reg;
    logic                             del_pend_reg;
    logic [fdsa_pkg::STAT_W-1:0]      t_status_reg;
    logic [IDX_W-1:0]                 t_idx_reg;
    logic [CNT_W-1:0]                 t_cnt_reg;

    logic                             ent_valid_reg [DIR_ENTRIES];
    logic [CNT_W-1:0]                 ent_cnt_reg   [DIR_ENTRIES];

    logic                             used_mem [DISK_SECTORS];
    logic                             used_rd_reg;
    logic [fdsa_pkg::NAME_W-1:0]      name_mem [DIR_ENTRIES];
    logic [fdsa_pkg::NAME_W-1:0]      name_rd_reg;
    logic [fdsa_pkg::SECNUM_W-1:0]    list_mem [LDEPTH];
    logic [fdsa_pkg::SECNUM_W-1:0]    lst_rd_reg;

    logic                             out_valid_reg;
    logic [fdsa_pkg::STAT_W-1:0]      out_status_reg;
    logic [IDX_W-1:0]                 out_idx_reg;
    logic                             out_sv_reg;
    logic [fdsa_pkg::SECNUM_W-1:0]    out_sec_reg;
    logic [CNT_W-1:0]                 out_cnt_reg;
    logic                             out_last_reg;

    logic [KW-1:0]                    km1;
    logic [IDX_W-1:0]                 cmp_idx;
    logic                             match_now, free_now, hit_any, free_any;
    logic [IDX_W-1:0]                 hit_idx, free_idx;
    logic                             scan_done;
    logic [CFG_W-1:0]                 lo;
    logic [CFG_W-1:0]                 s_inc;
    logic                             out_free;
    logic                             out_load;
    logic                             lst_rd_en;
    logic [LA_W-1:0]                  lst_addr;
    logic                             lst_wr_en;
    logic                             name_wr_en;
    logic                             claim;
    logic                             sec_end;
    logic                             used_wr_en;
    logic                             used_wr_data;
    logic [SEC_W-1:0]                 used_wr_addr;
    logic [SEC_W-1:0]                 used_rd_addr;
    logic [IDX_W+fdsa_pkg::EIDX_W-1:0] idx_ext;

    assign km1       = k_reg - KW'(1);
    assign cmp_idx   = km1[IDX_W-1:0];
    assign match_now = (k_reg != '0) && ent_valid_reg[cmp_idx] && (name_rd_reg == req_reg.key);
    assign free_now  = (k_reg != '0) && !ent_valid_reg[cmp_idx];
    assign hit_any   = hit_reg || match_now;
    assign free_any  = free_reg || free_now;
    assign hit_idx   = hit_reg ? hit_idx_reg : cmp_idx;
    assign free_idx  = free_reg ? free_idx_reg : cmp_idx;
    assign scan_done = (k_reg == KW'(DIR_ENTRIES));
    assign lo        = (reserved == '0) ? CFG_W'(1) : reserved;
    assign s_inc     = s_reg + CFG_W'(1);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign out_load  = out_free && ((state_reg == ST_OUT) || (state_reg == ST_TAIL));
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign sec_end   = (s_reg >= CFG_W'(DISK_SECTORS));
    assign claim     = (state_reg == ST_ALLOC) && (n_reg != req_reg.want) && !sec_end &&
                       !used_rd_reg;
    assign name_wr_en = (state_reg == ST_SCAN) && scan_done && !req_reg.empty_name &&
                        (req_reg.op == fdsa_pkg::OP_CREATE) && !hit_any && free_any;

    // The map read runs one sector ahead, so the word for s_reg is ready when
    // the sweep reaches it. The first word of a sweep is fetched during the
    // last scan cycle.
    always_comb
    begin
        used_rd_addr = (state_reg == ST_ALLOC) ? s_inc[SEC_W-1:0] : lo[SEC_W-1:0];
        used_wr_en   = (state_reg == ST_CLR) || claim || ((state_reg == ST_DEL) && del_pend_reg);
        used_wr_data = claim;
        if (state_reg == ST_DEL)
        begin
            used_wr_addr = lst_rd_reg[SEC_W-1:0];
        end
        else
        begin
            used_wr_addr = s_reg[SEC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_wr_en)
        begin
            used_mem[used_wr_addr] <= used_wr_data;
        end
        used_rd_reg <= used_mem[used_rd_addr];
    end

    // One list memory port: claims write, deletes and emission read.
    always_comb
    begin
        lst_wr_en = claim;
        lst_rd_en = ((state_reg == ST_DEL) && (i_reg != n_reg)) || (state_reg == ST_RD);
        if (claim)
        begin
            lst_addr = LA_W'(e_reg) * LA_W'(fdsa_pkg::MAX_FILE_SECTORS) + LA_W'(n_reg);
        end
        else
        begin
            lst_addr = LA_W'(e_reg) * LA_W'(fdsa_pkg::MAX_FILE_SECTORS) + LA_W'(i_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (lst_wr_en)
        begin
            list_mem[lst_addr] <= s_reg[fdsa_pkg::SECNUM_W-1:0];
        end
        if (lst_rd_en)
        begin
            lst_rd_reg <= list_mem[lst_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_wr_en)
        begin
            name_mem[free_idx] <= req_reg.key;
        end
        if ((state_reg == ST_SCAN) && !scan_done)
        begin
            name_rd_reg <= name_mem[k_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            k_reg          <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            e_reg          <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            s_reg          <= '0;
            tail_after_reg <= 1'b0;
            del_pend_reg   <= 1'b0;
            t_status_reg   <= fdsa_pkg::STAT_OK;
            t_idx_reg      <= '0;
            t_cnt_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= fdsa_pkg::STAT_OK;
            out_idx_reg    <= '0;
            out_sv_reg     <= 1'b0;
            out_sec_reg    <= '0;
            out_cnt_reg    <= '0;
            out_last_reg   <= 1'b0;
            for (int d = 0; d < DIR_ENTRIES; d++)
            begin
                ent_valid_reg[d] <= 1'b0;
                ent_cnt_reg[d]   <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !rsp_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR:
                begin
                    // After reset the map is cleared one sector a cycle.
                    s_reg <= s_inc;
                    if (s_reg == CFG_W'(DISK_SECTORS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        k_reg    <= '0;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                        if (q_head.empty_name)
                        begin
                            t_status_reg <= fdsa_pkg::STAT_NOT_FOUND;
                            t_idx_reg    <= '0;
                            t_cnt_reg    <= '0;
                            state_reg    <= ST_TAIL;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    k_reg <= k_reg + KW'(1);
                    if (match_now && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= cmp_idx;
                    end
                    if (free_now && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= cmp_idx;
                    end
                    if (scan_done)
                    begin
                        i_reg          <= '0;
                        tail_after_reg <= 1'b0;
                        del_pend_reg   <= 1'b0;
                        if (req_reg.op == fdsa_pkg::OP_CREATE)
                        begin
                            if (hit_any)
                            begin
                                t_status_reg <= fdsa_pkg::STAT_EXISTS;
                                t_idx_reg    <= hit_idx;
                                t_cnt_reg    <= ent_cnt_reg[hit_idx];
                                state_reg    <= ST_TAIL;
                            end
                            else if (!free_any)
                            begin
                                t_status_reg <= fdsa_pkg::STAT_DIR_FULL;
                                t_idx_reg    <= '0;
                                t_cnt_reg    <= '0;
                                state_reg    <= ST_TAIL;
                            end
                            else
                            begin
                                e_reg                   <= free_idx;
                                ent_valid_reg[free_idx] <= 1'b1;
                                n_reg                   <= '0;
                                s_reg                   <= lo;
                                state_reg               <= ST_ALLOC;
                            end
                        end
                        else if (!hit_any)
                        begin
                            t_status_reg <= fdsa_pkg::STAT_NOT_FOUND;
                            t_idx_reg    <= '0;
                            t_cnt_reg    <= '0;
                            state_reg    <= ST_TAIL;
                        end
                        else
                        begin
                            e_reg <= hit_idx;
                            n_reg <= ent_cnt_reg[hit_idx];
                            if (req_reg.op == fdsa_pkg::OP_DELETE)
                            begin
                                t_status_reg <= fdsa_pkg::STAT_OK;
                                t_idx_reg    <= hit_idx;
                                t_cnt_reg    <= ent_cnt_reg[hit_idx];
                                state_reg    <= ST_DEL;
                            end
                            else if (ent_cnt_reg[hit_idx] == '0)
                            begin
                                t_status_reg <= fdsa_pkg::STAT_OK;
                                t_idx_reg    <= hit_idx;
                                t_cnt_reg    <= '0;
                                state_reg    <= ST_TAIL;
                            end
                            else
                            begin
                                state_reg <= ST_RD;
                            end
                        end
                    end
                end
                ST_ALLOC:
                begin
                    // Claims only move upward, so one sweep of the map serves
                    // the whole request.
                    if (n_reg == req_reg.want || sec_end)
                    begin
                        ent_cnt_reg[e_reg] <= n_reg;
                        tail_after_reg     <= (n_reg != req_reg.want);
                        t_status_reg       <= (n_reg != req_reg.want) ?
                                              fdsa_pkg::STAT_DISK_FULL : fdsa_pkg::STAT_OK;
                        t_idx_reg          <= e_reg;
                        t_cnt_reg          <= n_reg;
                        i_reg              <= '0;
                        state_reg          <= (n_reg == '0) ? ST_TAIL : ST_RD;
                    end
                    else
                    begin
                        s_reg <= s_inc;
                        if (claim)
                        begin
                            n_reg <= n_reg + CNT_W'(1);
                        end
                    end
                end
                ST_DEL:
                begin
                    // Each read is followed by its map clear in the next cycle.
                    if (i_reg != n_reg)
                    begin
                        i_reg        <= i_reg + CNT_W'(1);
                        del_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        del_pend_reg <= 1'b0;
                    end
                    if (i_reg == n_reg && !del_pend_reg)
                    begin
                        ent_valid_reg[e_reg] <= 1'b0;
                        ent_cnt_reg[e_reg]   <= '0;
                        state_reg            <= ST_TAIL;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= fdsa_pkg::STAT_OK;
                        out_idx_reg    <= e_reg;
                        out_sv_reg     <= 1'b1;
                        out_sec_reg    <= lst_rd_reg;
                        out_cnt_reg    <= n_reg;
                        out_last_reg   <= (i_reg == n_reg - CNT_W'(1)) && !tail_after_reg;
                        i_reg          <= i_reg + CNT_W'(1);
                        if (i_reg == n_reg - CNT_W'(1))
                        begin
                            state_reg <= tail_after_reg ? ST_TAIL : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_TAIL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= t_status_reg;
                        out_idx_reg    <= t_idx_reg;
                        out_sv_reg     <= 1'b0;
                        out_sec_reg    <= '0;
                        out_cnt_reg    <= t_cnt_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idx_ext       = {{fdsa_pkg::EIDX_W{1'b0}}, out_idx_reg};
    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign entry_index   = idx_ext[fdsa_pkg::EIDX_W-1:0];
    assign sector_valid  = out_sv_reg;
    assign sector_number = out_sec_reg;
    assign file_sectors  = out_cnt_reg;
    assign last          = out_last_reg;

endmodule

// ===== src/file_directory_sector_allocator_top.sv =====
// Flat file directory with a used-sector map.
// Request channel: req_valid / req_stall with opcode, file_name and
// sector_count; a request is taken when req_valid is high and req_stall low.
// Unknown opcodes are taken and produce no response.
// Response channel: rsp_valid / rsp_stall; each request yields one or more
// responses, the final one flagged by last.
// Config channel: cfg_valid / cfg_ready writes reserved_sectors; cfg_ready
// is always high. Write it only while no request is in flight.
// A two-entry queue sits between the request side and the sequencer, so
// requests are taken while the sequencer works or the receiver stalls.
// The sequencer picks a request from the queue in its idle state and then
// scans the directory (an empty name skips the scan). A create then sweeps
// the sector map one sector a cycle up to the last sector; a delete reads
// each listed sector and frees it in the map, then clears the entry. Every
// listed sector is read from the single-port list memory and then loaded
// into the output register, a status-only response is loaded directly. A held
// rsp_stall freezes the output register and the sequencer waits on it. Reset empties
// the directory and sets reserved_sectors to 3; the sector map is then
// cleared in full while requests wait in the queue.
module file_directory_sector_allocator_top
#(
    parameter int DIR_ENTRIES  = fdsa_pkg::DIR_ENTRIES,
    parameter int DISK_SECTORS = fdsa_pkg::DISK_SECTORS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdsa_pkg::CFG_W-1:0]       reserved_sectors,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [fdsa_pkg::OP_W-1:0]        opcode,
    input  logic [47:0]                      file_name,
    input  logic [fdsa_pkg::CNT_W-1:0]       sector_count,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [fdsa_pkg::STAT_W-1:0]      status,
    output logic [fdsa_pkg::EIDX_W-1:0]      entry_index,
    output logic                             sector_valid,
    output logic [fdsa_pkg::SECNUM_W-1:0]    sector_number,
    output logic [fdsa_pkg::CNT_W-1:0]       file_sectors,
    output logic                             last
);

    logic [fdsa_pkg::CFG_W-1:0] reserved_reg;
    logic                       q_full, q_empty, q_push, q_pop;
    fdsa_pkg::req_t             q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= fdsa_pkg::RESERVED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reserved_reg <= reserved_sectors;
        end
    end

    fdsa_front u_front
    (
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .file_name    (file_name),
        .sector_count (sector_count),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    fdsa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    fdsa_back
    #(
        .DIR_ENTRIES  (DIR_ENTRIES),
        .DISK_SECTORS (DISK_SECTORS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .reserved      (reserved_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .entry_index   (entry_index),
        .sector_valid  (sector_valid),
        .sector_number (sector_number),
        .file_sectors  (file_sectors),
        .last          (last)
    );

endmodule

// ===== src/fdsa_checker.sv =====
`include "assert_macros.svh"

module fdsa_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic [fdsa_pkg::STAT_W-1:0]      status,
    input  logic [fdsa_pkg::EIDX_W-1:0]      entry_index,
    input  logic                             sector_valid,
    input  logic [fdsa_pkg::SECNUM_W-1:0]    sector_number,
    input  logic [fdsa_pkg::CNT_W-1:0]       file_sectors,
    input  logic                             last
);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

    // Listed sectors only come with an ok status.
    `ASSERT_CLK(a_sector_ok, clk, rst_n, rsp_valid && sector_valid |-> status == fdsa_pkg::STAT_OK, "sector with error status")

    // A status-only response carries no sector and always ends the request.
    `ASSERT_CLK(a_status_last, clk, rst_n, rsp_valid && !sector_valid |-> sector_number == '0 && last, "status response malformed")

    `ASSERT_CLK(a_not_found, clk, rst_n, rsp_valid && status == fdsa_pkg::STAT_NOT_FOUND |-> entry_index == '0 && file_sectors == '0, "not-found response carries data")

endmodule

bind file_directory_sector_allocator_top fdsa_checker u_fdsa_checker (.*);
